@@ sv/smru_pkg.sv @@
// ----------------------------------------------------------------------------
// smru_pkg
// Types and constants shared by the short masked run unmasking filter.
// ----------------------------------------------------------------------------
package smru_pkg;

	// Bytes at or above this code count as masked.
	localparam logic [7:0] MASKED_FROM = 8'h61;
	localparam logic [7:0] LOWER_LAST  = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int unsigned COUNT_W = 16;

	localparam logic [1:0] VERDICT_KEPT      = 2'd0;
	localparam logic [1:0] VERDICT_SHORT     = 2'd1;
	localparam logic [1:0] VERDICT_UNMASKED  = 2'd2;

	typedef struct packed {
		logic [7:0] base;
		logic [7:0] quality;
		logic       last_of_read;
	} item_t;

	typedef struct packed {
		logic [7:0] base_out;
		logic [8:0] quality_out;
		logic       last_of_burst;
		logic       end_of_read;
		logic [1:0] verdict;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEND_MEM,
		S_SEND_DIRECT
	} state_t;

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		if (b >= MASKED_FROM && b <= LOWER_LAST) begin
			return b - CASE_OFFSET;
		end
		return b;
	endfunction

endpackage

@@ sv/smru_ram.sv @@
// ----------------------------------------------------------------------------
// smru_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smru_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/short_mask_run_unmask_filter.sv @@
// ----------------------------------------------------------------------------
// short_mask_run_unmask_filter
// Turns short lowercase (masked) runs of a read to uppercase, adds one to
// every quality and gives a verdict on the last word of each read.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------
//  item     | item_valid / item_stall   | smru_pkg::item_t
//  result   | result_valid / result_stall | smru_pkg::result_t
//  cfg      | cfg_we                    | cfg_wdata (min_length)
//
// A direct base is accepted in S_IDLE and then loaded into the output
// register from S_SEND_DIRECT. A flush issues the first RAM read in S_READ;
// S_SEND_MEM then loads one pending base per cycle while the output is free,
// fetching the next entry meanwhile. item_stall holds until S_IDLE. The
// pending RAM read port sets the flush rate. Reset clears all control
// state; the RAM needs no clearing. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module short_mask_run_unmask_filter #(
	parameter int unsigned MASK_RUN_MIN    = 40,
	parameter int unsigned MAX_READ_LENGTH = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  smru_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output smru_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);

	localparam int unsigned AW = $clog2(MASK_RUN_MIN);
	localparam int unsigned CW = $clog2(MASK_RUN_MIN + 1);
	localparam logic [CW-1:0] RUN_LIMIT = CW'(MASK_RUN_MIN);
	localparam logic [smru_pkg::COUNT_W-1:0] LEN_MAX =
		smru_pkg::COUNT_W'(MAX_READ_LENGTH);

	smru_pkg::state_t  state_q, state_d;
	smru_pkg::item_t   item_q;
	smru_pkg::result_t result_q, ld_res;

	logic                          result_valid_q;
	logic [15:0]                   min_length_q;
	logic [CW-1:0]                 cnt_q, idx_q, fl_n_q;
	logic                          long_q, upper_q, direct_q, last_q;
	logic [smru_pkg::COUNT_W-1:0]  read_len_q, unm_q, unm_next;

	logic          accept, out_free, ld;
	logic          masked, store, reach;
	logic [CW-1:0] cnt_inc, flush_n, idx_inc;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rdata;
	logic [7:0]    mem_base;
	logic          fin;

	assign accept     = item_valid && (state_q == smru_pkg::S_IDLE);
	assign item_stall = (state_q != smru_pkg::S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;

	// Decode of the word being accepted.
	always_comb begin
		masked  = (item.base >= smru_pkg::MASKED_FROM);
		store   = masked && !long_q;
		cnt_inc = cnt_q + CW'(1);
		reach   = store && (cnt_inc == RUN_LIMIT);
		if (!masked) begin
			flush_n = cnt_q;
		end else if (store && (reach || item.last_of_read)) begin
			flush_n = cnt_inc;
		end else begin
			flush_n = '0;
		end
	end

	// The RAM is written only on accept and read only while the sequencer is
	// busy, so a write and a read of the same entry never overlap.
	smru_ram #(
		.WIDTH(16),
		.DEPTH(MASK_RUN_MIN)
	) u_pending (
		.clk  (clk),
		.we   (accept && store),
		.waddr(cnt_q[AW-1:0]),
		.wdata({item.quality, item.base}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_comb begin
		state_d  = state_q;
		ld       = 1'b0;
		ld_res   = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		idx_inc  = idx_q + CW'(1);
		fin      = (idx_inc == fl_n_q);
		mem_base = upper_q ? smru_pkg::to_upper(rdata[7:0]) : rdata[7:0];
		case (state_q)
			smru_pkg::S_IDLE: begin
				if (accept) begin
					if (flush_n != '0) begin
						state_d = smru_pkg::S_READ;
					end else if (!store) begin
						state_d = smru_pkg::S_SEND_DIRECT;
					end
				end
			end
			smru_pkg::S_READ: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
				state_d = smru_pkg::S_SEND_MEM;
			end
			smru_pkg::S_SEND_MEM: begin
				if (out_free) begin
					ld                   = 1'b1;
					ld_res.base_out      = mem_base;
					ld_res.quality_out   = {1'b0, rdata[15:8]} + 9'd1;
					ld_res.last_of_burst = fin && !direct_q;
					ld_res.end_of_read   = fin && !direct_q && last_q;
					if (!fin) begin
						// Fetch the next entry while this one is loaded.
						rd_en   = 1'b1;
						rd_addr = idx_inc[AW-1:0];
					end else if (direct_q) begin
						state_d = smru_pkg::S_SEND_DIRECT;
					end else begin
						state_d = smru_pkg::S_IDLE;
					end
				end
			end
			smru_pkg::S_SEND_DIRECT: begin
				if (out_free) begin
					ld                   = 1'b1;
					ld_res.base_out      = item_q.base;
					ld_res.quality_out   = {1'b0, item_q.quality} + 9'd1;
					ld_res.last_of_burst = 1'b1;
					ld_res.end_of_read   = last_q;
					state_d              = smru_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smru_pkg::S_IDLE;
			end
		endcase

		// The verdict counts the word being loaded as well.
		if (ld_res.base_out < smru_pkg::MASKED_FROM && unm_q < LEN_MAX) begin
			unm_next = unm_q + 16'd1;
		end else begin
			unm_next = unm_q;
		end
		if (ld_res.end_of_read) begin
			if (read_len_q < min_length_q) begin
				ld_res.verdict = smru_pkg::VERDICT_SHORT;
			end else if (unm_next < min_length_q) begin
				ld_res.verdict = smru_pkg::VERDICT_UNMASKED;
			end else begin
				ld_res.verdict = smru_pkg::VERDICT_KEPT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= smru_pkg::S_IDLE;
			result_valid_q <= 1'b0;
			min_length_q   <= 16'd100;
			cnt_q          <= '0;
			idx_q          <= '0;
			fl_n_q         <= '0;
			long_q         <= 1'b0;
			upper_q        <= 1'b0;
			direct_q       <= 1'b0;
			last_q         <= 1'b0;
			read_len_q     <= '0;
			unm_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				min_length_q <= cfg_wdata;
			end
			if (ld) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q    <= '0;
				fl_n_q   <= flush_n;
				upper_q  <= !reach;
				direct_q <= !store;
				last_q   <= item.last_of_read;
				if (read_len_q < LEN_MAX) begin
					read_len_q <= read_len_q + 16'd1;
				end
				if (flush_n != '0 || item.last_of_read) begin
					cnt_q <= '0;
				end else if (store) begin
					cnt_q <= cnt_inc;
				end
				if (item.last_of_read || !masked) begin
					long_q <= 1'b0;
				end else if (reach) begin
					long_q <= 1'b1;
				end
			end
			if (ld && state_q == smru_pkg::S_SEND_MEM) begin
				idx_q <= idx_inc;
			end
			if (ld) begin
				if (ld_res.end_of_read) begin
					read_len_q <= '0;
					unm_q      <= '0;
				end else begin
					unm_q <= unm_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (ld) begin
			result_q <= ld_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < RUN_LIMIT)
		else $error("pending count reached the run limit while held");

	a_long_empty: assert property (@(posedge clk) disable iff (!arst_n)
		long_q |-> (cnt_q == '0))
		else $error("long run open with bases still pending");

	a_end_is_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.end_of_read) |-> result_q.last_of_burst)
		else $error("end of read on a word that does not close its burst");

	a_verdict_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.end_of_read) |->
			(result_q.verdict == smru_pkg::VERDICT_KEPT))
		else $error("verdict set on a word that does not end the read");

	a_counters_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_res.end_of_read) |=> (read_len_q == '0 && unm_q == '0))
		else $error("read counters not cleared after end of read");

endmodule

@@ test/short_mask_run_unmask_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// short_mask_run_unmask_filter_tb
// Self-checking bench for the short masked run filter. Reads are sent word by
// word under random idling on both channels. A model kept in the bench
// predicts every result word, and each result word is checked field by field.
// ----------------------------------------------------------------------------
module short_mask_run_unmask_filter_tb;

	localparam int unsigned RUN_LIMIT     = 40;
	localparam int unsigned LENGTH_CAP    = 65535;
	localparam int          SETTLE_CYCLES = 2 * RUN_LIMIT + 20;
	localparam int          TIMEOUT_NS    = 4000000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	smru_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	smru_pkg::result_t result;
	logic              cfg_we       = 1'b0;
	logic [15:0]       cfg_wdata    = '0;

	// Bench copy of the run buffer, the read counters and the register.
	logic [15:0] run_buffer [RUN_LIMIT];
	int unsigned run_fill     = 0;
	bit          long_run     = 1'b0;
	int unsigned read_len     = 0;
	int unsigned unmasked_len = 0;
	logic [15:0] min_len      = 16'd100;
	smru_pkg::result_t burst_words    [$];
	smru_pkg::result_t expected_words [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_in      = 0;
	int words_out     = 0;
	int errors        = 0;
	int verdict_tally [4] = '{0, 0, 0, 0};

	short_mask_run_unmask_filter #(
		.MASK_RUN_MIN    (RUN_LIMIT),
		.MAX_READ_LENGTH (LENGTH_CAP)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [7:0] raise_case(input logic [7:0] b);
		if (b >= "a" && b <= "z") begin
			return b & 8'hdf;
		end
		return b;
	endfunction

	function automatic void put_word(input logic [7:0] b, input logic [7:0] q);
		smru_pkg::result_t r;
		r = '0;
		r.base_out = b;
		r.quality_out = {1'b0, q} + 9'd1;
		if (b < smru_pkg::MASKED_FROM && unmasked_len < LENGTH_CAP) begin
			unmasked_len++;
		end
		burst_words.push_back(r);
	endfunction

	function automatic void flush_run(input bit upper);
		for (int i = 0; i < run_fill; i++) begin
			put_word(upper ? raise_case(run_buffer[i][7:0]) : run_buffer[i][7:0],
				run_buffer[i][15:8]);
		end
		run_fill = 0;
	endfunction

	// Works out the result words of one accepted word and queues them.
	function automatic void predict_words(input smru_pkg::item_t w);
		smru_pkg::result_t tail;
		burst_words.delete();
		if (read_len < LENGTH_CAP) begin
			read_len++;
		end
		if (w.base < smru_pkg::MASKED_FROM) begin
			flush_run(1'b1);
			long_run = 1'b0;
			put_word(w.base, w.quality);
		end else if (long_run) begin
			put_word(w.base, w.quality);
		end else begin
			run_buffer[run_fill] = {w.quality, w.base};
			run_fill++;
			if (run_fill >= RUN_LIMIT) begin
				flush_run(1'b0);
				long_run = 1'b1;
			end
		end
		if (w.last_of_read) begin
			flush_run(1'b1);
			tail = burst_words.pop_back();
			tail.end_of_read = 1'b1;
			if (read_len < min_len) begin
				tail.verdict = smru_pkg::VERDICT_SHORT;
			end else if (unmasked_len < min_len) begin
				tail.verdict = smru_pkg::VERDICT_UNMASKED;
			end else begin
				tail.verdict = smru_pkg::VERDICT_KEPT;
			end
			burst_words.push_back(tail);
			long_run = 1'b0;
			read_len = 0;
			unmasked_len = 0;
		end
		if (burst_words.size() != 0) begin
			tail = burst_words.pop_back();
			tail.last_of_burst = 1'b1;
			burst_words.push_back(tail);
		end
		foreach (burst_words[i]) begin
			expected_words.push_back(burst_words[i]);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("result word %0d: %s is %0h, expected %0h", words_out, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		smru_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			words_out++;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word, base_out", result.base_out, 0);
			end else begin
				want = expected_words.pop_front();
				if (result.base_out !== want.base_out)
					report_mismatch("base_out", result.base_out, want.base_out);
				if (result.quality_out !== want.quality_out)
					report_mismatch("quality_out", result.quality_out, want.quality_out);
				if (result.last_of_burst !== want.last_of_burst)
					report_mismatch("last_of_burst", result.last_of_burst, want.last_of_burst);
				if (result.end_of_read !== want.end_of_read)
					report_mismatch("end_of_read", result.end_of_read, want.end_of_read);
				if (result.verdict !== want.verdict)
					report_mismatch("verdict", result.verdict, want.verdict);
				if (want.end_of_read) begin
					verdict_tally[want.verdict]++;
				end
			end
		end
	end

	task automatic send_word(input smru_pkg::item_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		predict_words(w);
		items_in++;
	endtask

	// Holds the input until every expected word is out, then lets a held run
	// settle inside the block.
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_length(input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		min_len = value;
	endtask

	task automatic send_read(input logic [7:0] bases [$]);
		smru_pkg::item_t w;
		foreach (bases[i]) begin
			w.base = bases[i];
			if (i % 3 == 0) begin
				w.quality = 8'h00;
			end else if (i % 3 == 1) begin
				w.quality = 8'hff;
			end else begin
				w.quality = 8'($urandom_range(255));
			end
			w.last_of_read = (i == bases.size() - 1);
			send_word(w);
		end
	endtask

	function automatic logic [7:0] pick_base(input bit masked);
		logic [7:0] nuc;
		if ($urandom_range(99) < 15) begin
			if (masked) begin
				return 8'($urandom_range(255, smru_pkg::MASKED_FROM));
			end
			return 8'($urandom_range(smru_pkg::MASKED_FROM - 1, 0));
		end
		case ($urandom_range(4))
			0: nuc = "A";
			1: nuc = "C";
			2: nuc = "G";
			3: nuc = "T";
			default: nuc = "N";
		endcase
		return masked ? raise_case(nuc) ^ 8'h20 : nuc;
	endfunction

	// Mostly well-formed reads built from runs; some reads are plain noise.
	task automatic send_random_read();
		int    len;
		int    run;
		int    sent;
		bit    noise;
		bit    masked;
		smru_pkg::item_t w;
		noise = ($urandom_range(99) < 15);
		if (noise) begin
			len = $urandom_range(12, 1);
		end else if ($urandom_range(99) < 70) begin
			len = $urandom_range(30, 1);
		end else begin
			len = $urandom_range(90, 40);
		end
		sent = 0;
		while (sent < len) begin
			masked = $urandom_range(1);
			if (!masked) begin
				run = $urandom_range(10, 1);
			end else begin
				case ($urandom_range(9))
					0, 1, 2: run = $urandom_range(RUN_LIMIT + 5, RUN_LIMIT - 4);
					3: run = $urandom_range(RUN_LIMIT - 1, 1);
					default: run = $urandom_range(10, 1);
				endcase
			end
			for (int k = 0; k < run && sent < len; k++) begin
				w.base = noise ? 8'($urandom_range(255)) : pick_base(masked);
				w.quality = 8'($urandom_range(255));
				w.last_of_read = (sent == len - 1);
				send_word(w);
				sent++;
			end
		end
	endtask

	task automatic test_reset_min_length();
		logic [7:0] bases [$];
		bases = '{"A", "C", "g", "T", "N"};
		send_read(bases);
	endtask

	task automatic test_edge_bytes();
		logic [7:0] bases [$];
		wait_drained();
		write_min_length(16'd4);
		// Bytes past 'z' stay as they are inside a short run.
		bases = '{8'h00, "a", "z", 8'h7b, 8'hff, "C"};
		send_read(bases);
		bases = '{"n"};
		send_read(bases);
		bases = '{8'h60};
		send_read(bases);
	endtask

	task automatic test_verdicts();
		logic [7:0] bases [$];
		bases = '{"G", "c", "g"};
		send_read(bases);
		bases = '{8'h7b, 8'h7c, 8'hff, 8'h80, "T"};
		send_read(bases);
		bases = '{"A", "C", "G", "T"};
		send_read(bases);
	endtask

	task automatic test_run_limit();
		logic [7:0] bases [$];
		wait_drained();
		write_min_length(16'd0);
		bases.delete();
		bases.push_back("A");
		repeat (RUN_LIMIT) bases.push_back("c");
		repeat (3) bases.push_back("g");
		bases.push_back("T");
		repeat (RUN_LIMIT - 1) bases.push_back("a");
		bases.push_back("C");
		send_read(bases);
		// The run reaches the limit on the last word of the read.
		bases.delete();
		repeat (RUN_LIMIT - 1) bases.push_back("t");
		bases.push_back("g");
		send_read(bases);
	endtask

	task automatic test_random(input int send_pct, input int recv_pct,
			input logic [15:0] setting, input int goal);
		int first;
		wait_drained();
		write_min_length(setting);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		first = items_in;
		while (items_in - first < goal) begin
			if ($urandom_range(24) == 0) begin
				wait_drained();
			end
			send_random_read();
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 19;
		recv_idle_pct = 47;
		test_reset_min_length();
		test_edge_bytes();
		test_verdicts();
		test_run_limit();
		test_random(19, 47, 16'd30, 80);
		test_random(47, 19, 16'd12, 80);
		test_random(0, 0, 16'd50, 80);
		wait_drained();
		$display("%0d words in, %0d result words out; reads kept %0d, too short %0d, %s %0d",
			items_in, words_out, verdict_tally[smru_pkg::VERDICT_KEPT],
			verdict_tally[smru_pkg::VERDICT_SHORT],
			"too few unmasked", verdict_tally[smru_pkg::VERDICT_UNMASKED]);
		$display("min_length at 100, 4, 0, 30, 12, 50; runs at and past the limit");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d words in and %0d result words out", items_in, words_out);
		$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/smru_pkg.sv
sv/smru_ram.sv
sv/short_mask_run_unmask_filter.sv
test/short_mask_run_unmask_filter_tb.sv
